FILE: rtl/spd_pkg.sv
package spd_pkg;

   localparam int DEF_MAX_HALF_WINDOW = 64;
   localparam int DEF_INDEX_BITS      = 16;

   localparam int PRICE_W     = 32;
   localparam int STAMP_W     = 32;
   localparam int OUT_INDEX_W = 16;
   localparam int CSR_W       = 7;

   localparam logic [CSR_W-1:0] HALF_WINDOW_RESET = 7'd50;

   localparam logic KIND_LOW  = 1'b0;
   localparam logic KIND_HIGH = 1'b1;

   typedef struct packed {
      logic [OUT_INDEX_W-1:0] index;
      logic                   kind;
      logic [PRICE_W-1:0]     level;
      logic [STAMP_W-1:0]     stamp;
      logic                   run_end;
   } swing_type;

   typedef struct packed {
      logic is_high;
      logic is_low;
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_DECIDE,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/swing_point_detector_core.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_tvalid/tready   | tdata: bar_high, bar_low, bar_time; tlast: final_bar
// rsp     | out       | rsp_tvalid/tready   | tdata: swing_index, swing_level, swing_time;
//         |           |                     | tuser: swing_kind; tlast: run_end
// csr     | in        | csr_wr_en           | csr_wr_data: half_window
//
// A bar passes through accept, compare in the cell row and decide, then through emit for
// its result words, 0 to 3 of them; the candidate read from the history RAM and the
// registered compare flags of the cell row are what require the compare and decide states.
// Reset is synchronous: half_window returns to 50, the series restarts at bar 0.
// A stalled rsp holds the block in its emit state; no bar is taken until all words go out.
module swing_point_detector_core import spd_pkg::*; #(
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
   parameter int INDEX_BITS      = DEF_INDEX_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [95:0]      req_tdata,   // bar_high[31:0], bar_low[63:32], bar_time[95:64]
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [79:0]      rsp_tdata,   // swing_index[15:0], swing_level[47:16], swing_time[79:48]
   output logic             rsp_tuser,   // swing_kind
   output logic             rsp_tlast,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int WW        = $clog2(MAX_HALF_WINDOW + 1);
   localparam int RAM_DEPTH = 1 << WW;
   localparam int RAM_W     = PRICE_W + PRICE_W + STAMP_W;
   localparam int CW        = (WW > CSR_W) ? WW : CSR_W;
   localparam int JW        = (INDEX_BITS > WW + 1) ? INDEX_BITS : WW + 1;

   state_type state_ff, state_in;

   logic [CSR_W-1:0]      half_window_ff, half_window_in;
   logic [INDEX_BITS-1:0] bar_count_ff, bar_count_in;
   logic [WW-1:0]         ptr_ff, ptr_in;
   logic [PRICE_W-1:0]    first_high_ff, first_high_in;
   logic [PRICE_W-1:0]    first_low_ff, first_low_in;
   logic [STAMP_W-1:0]    first_stamp_ff, first_stamp_in;
   logic [PRICE_W-1:0]    bar_high_ff, bar_high_in;
   logic [PRICE_W-1:0]    bar_low_ff, bar_low_in;
   logic [STAMP_W-1:0]    bar_stamp_ff, bar_stamp_in;
   logic                  bar_final_ff, bar_final_in;
   logic [INDEX_BITS-1:0] cur_ff, cur_in;
   logic [WW-1:0]         win_ff, win_in;
   swing_type             pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  seen_ff, seen_in;
   swing_type             slot_ff [3];
   swing_type             slot_in [3];
   logic [1:0]            slot_cnt_ff, slot_cnt_in;
   logic [1:0]            emit_idx_ff, emit_idx_in;

   logic [PRICE_W-1:0] req_high;
   logic [PRICE_W-1:0] req_low;
   logic [STAMP_W-1:0] req_stamp;
   logic               accept;
   logic               deliver;
   logic [CW-1:0]      hw_ext;
   logic [WW-1:0]      w_eff;
   logic [RAM_W-1:0]   ram_rd_data;
   logic [PRICE_W-1:0] cand_high;
   logic [PRICE_W-1:0] cand_low;
   logic [STAMP_W-1:0] cand_stamp;
   verdict_type        verdict;
   logic               judge;
   logic               found;
   logic               better;
   swing_type          new_swing;
   swing_type          bar0_swing;
   swing_type          close_swing;
   swing_type          out_word;

   assign req_high  = req_tdata[PRICE_W-1:0];
   assign req_low   = req_tdata[2*PRICE_W-1:PRICE_W];
   assign req_stamp = req_tdata[RAM_W-1:2*PRICE_W];

   assign accept  = req_tvalid && req_tready;
   assign deliver = rsp_tvalid && rsp_tready;

   // clamp the window to 1..MAX_HALF_WINDOW
   assign hw_ext = CW'(half_window_ff);
   always_comb begin
      if (hw_ext == '0) begin
         w_eff = WW'(1);
      end else if (hw_ext > CW'(MAX_HALF_WINDOW)) begin
         w_eff = WW'(MAX_HALF_WINDOW);
      end else begin
         w_eff = WW'(hw_ext);
      end
   end

   spd_ram #(
      .WIDTH (RAM_W),
      .DEPTH (RAM_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ptr_ff),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr (ptr_ff - w_eff),
      .rd_data (ram_rd_data)
   );

   assign cand_high  = ram_rd_data[PRICE_W-1:0];
   assign cand_low   = ram_rd_data[2*PRICE_W-1:PRICE_W];
   assign cand_stamp = ram_rd_data[RAM_W-1:2*PRICE_W];

   spd_chain #(
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
   ) u_chain (
      .clock     (clock),
      .shift_en  (accept),
      .bar_high  (req_high),
      .bar_low   (req_low),
      .cmp_en    (state_ff == ST_COMPARE),
      .cand_high (cand_high),
      .cand_low  (cand_low),
      .win       (win_ff),
      .verdict   (verdict)
   );

   // candidate bar is judged once all 2W+1 window bars belong to this series
   assign judge = JW'(cur_ff) >= (JW'(win_ff) << 1);
   assign found = judge && (verdict.is_high || verdict.is_low);

   always_comb begin
      new_swing.index   = OUT_INDEX_W'(JW'(cur_ff) - JW'(win_ff));
      new_swing.kind    = verdict.is_high ? KIND_HIGH : KIND_LOW;
      new_swing.level   = verdict.is_high ? cand_high : cand_low;
      new_swing.stamp   = cand_stamp;
      new_swing.run_end = 1'b0;

      bar0_swing.index   = '0;
      bar0_swing.kind    = ~new_swing.kind;
      bar0_swing.level   = (bar0_swing.kind == KIND_HIGH) ? first_high_ff : first_low_ff;
      bar0_swing.stamp   = first_stamp_ff;
      bar0_swing.run_end = 1'b0;

      if (new_swing.kind == KIND_HIGH) begin
         better = new_swing.level > pend_ff.level;
      end else begin
         better = new_swing.level < pend_ff.level;
      end
   end

   // bar intake, window CSR write, counters and history
   always_comb begin
      half_window_in = csr_wr_en ? csr_wr_data : half_window_ff;
      bar_count_in   = bar_count_ff;
      ptr_in         = ptr_ff;
      first_high_in  = first_high_ff;
      first_low_in   = first_low_ff;
      first_stamp_in = first_stamp_ff;
      bar_high_in    = bar_high_ff;
      bar_low_in     = bar_low_ff;
      bar_stamp_in   = bar_stamp_ff;
      bar_final_in   = bar_final_ff;
      cur_in         = cur_ff;
      win_in         = win_ff;
      if (accept) begin
         ptr_in       = ptr_ff + WW'(1);
         bar_high_in  = req_high;
         bar_low_in   = req_low;
         bar_stamp_in = req_stamp;
         bar_final_in = req_tlast;
         cur_in       = bar_count_ff;
         win_in       = w_eff;
         if (bar_count_ff == '0) begin
            first_high_in  = req_high;
            first_low_in   = req_low;
            first_stamp_in = req_stamp;
         end
         if (req_tlast) begin
            bar_count_in = '0;
         end else if (!(&bar_count_ff)) begin
            bar_count_in = bar_count_ff + INDEX_BITS'(1);
         end
      end
   end

   // swing bookkeeping and result words
   always_comb begin
      logic [1:0] n;
      n             = 2'd0;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      seen_in       = seen_ff;
      slot_in       = slot_ff;
      slot_cnt_in   = slot_cnt_ff;
      emit_idx_in   = emit_idx_ff;

      close_swing.index   = OUT_INDEX_W'(cur_ff);
      close_swing.kind    = KIND_LOW;
      close_swing.level   = bar_low_ff;
      close_swing.stamp   = bar_stamp_ff;
      close_swing.run_end = 1'b1;

      if (state_ff == ST_DECIDE) begin
         if (found) begin
            if (!pend_valid_ff) begin
               if (!seen_ff) begin
                  slot_in[n] = bar0_swing;
                  n          = n + 2'd1;
                  seen_in    = 1'b1;
               end
               pend_in       = new_swing;
               pend_valid_in = 1'b1;
            end else if (pend_ff.kind == new_swing.kind) begin
               if (better) begin
                  pend_in = new_swing;
               end
            end else begin
               slot_in[n] = pend_ff;
               n          = n + 2'd1;
               pend_in    = new_swing;
            end
         end
         if (bar_final_ff) begin
            if (pend_valid_in) begin
               close_swing.kind  = ~pend_in.kind;
               close_swing.level = (close_swing.kind == KIND_HIGH) ? bar_high_ff : bar_low_ff;
               slot_in[n] = pend_in;
               n          = n + 2'd1;
               slot_in[n] = close_swing;
               n          = n + 2'd1;
            end
            pend_valid_in = 1'b0;
            seen_in       = 1'b0;
         end
         slot_cnt_in = n;
         emit_idx_in = 2'd0;
      end else if (deliver) begin
         emit_idx_in = emit_idx_ff + 2'd1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = (slot_cnt_in == 2'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (deliver && (emit_idx_ff == slot_cnt_ff - 2'd1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         half_window_ff <= HALF_WINDOW_RESET;
         bar_count_ff   <= '0;
         ptr_ff         <= '0;
         first_high_ff  <= '0;
         first_low_ff   <= '0;
         first_stamp_ff <= '0;
         pend_valid_ff  <= 1'b0;
         seen_ff        <= 1'b0;
         slot_cnt_ff    <= 2'd0;
         emit_idx_ff    <= 2'd0;
      end else begin
         state_ff       <= state_in;
         half_window_ff <= half_window_in;
         bar_count_ff   <= bar_count_in;
         ptr_ff         <= ptr_in;
         first_high_ff  <= first_high_in;
         first_low_ff   <= first_low_in;
         first_stamp_ff <= first_stamp_in;
         pend_valid_ff  <= pend_valid_in;
         seen_ff        <= seen_in;
         slot_cnt_ff    <= slot_cnt_in;
         emit_idx_ff    <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bar_high_ff  <= bar_high_in;
      bar_low_ff   <= bar_low_in;
      bar_stamp_ff <= bar_stamp_in;
      bar_final_ff <= bar_final_in;
      cur_ff       <= cur_in;
      win_ff       <= win_in;
      pend_ff      <= pend_in;
      slot_ff      <= slot_in;
   end

   assign out_word  = slot_ff[emit_idx_ff];
   assign rsp_tdata = {out_word.stamp, out_word.level, out_word.index};
   assign rsp_tuser = out_word.kind;
   assign rsp_tlast = out_word.run_end;

endmodule

FILE: rtl/spd_ram.sv
module spd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/spd_cell.sv
module spd_cell import spd_pkg::*; #(
   parameter int POS = 0,
   parameter int WW  = 7
) (
   input  logic               clock,
   input  logic               shift_en,
   input  logic [PRICE_W-1:0] prev_high,
   input  logic [PRICE_W-1:0] prev_low,
   output logic [PRICE_W-1:0] cell_high,
   output logic [PRICE_W-1:0] cell_low,
   input  logic               cmp_en,
   input  logic [PRICE_W-1:0] cand_high,
   input  logic [PRICE_W-1:0] cand_low,
   input  logic [WW-1:0]      win,
   output logic               high_kill,
   output logic               low_kill
);

   localparam int SW = WW + 1;
   localparam logic [SW-1:0] MY_POS = SW'(POS);

   logic [PRICE_W-1:0] high_ff, high_in;
   logic [PRICE_W-1:0] low_ff, low_in;
   logic               high_kill_ff, high_kill_in;
   logic               low_kill_ff, low_kill_in;
   logic               later;
   logic               earlier;
   logic [SW-1:0]      win_ext;
   logic [SW-1:0]      span;

   assign win_ext = {1'b0, win};
   assign span    = {win, 1'b0};
   // newer bars sit below the candidate, older ones above it
   assign later   = MY_POS < win_ext;
   assign earlier = (MY_POS > win_ext) && (MY_POS <= span);

   always_comb begin
      high_in      = shift_en ? prev_high : high_ff;
      low_in       = shift_en ? prev_low  : low_ff;
      high_kill_in = high_kill_ff;
      low_kill_in  = low_kill_ff;
      if (cmp_en) begin
         high_kill_in = (later   && (high_ff >= cand_high)) ||
                        (earlier && (high_ff >  cand_high));
         low_kill_in  = (later   && (low_ff  <= cand_low)) ||
                        (earlier && (low_ff  <  cand_low));
      end
   end

   always_ff @(posedge clock) begin
      high_ff      <= high_in;
      low_ff       <= low_in;
      high_kill_ff <= high_kill_in;
      low_kill_ff  <= low_kill_in;
   end

   assign cell_high = high_ff;
   assign cell_low  = low_ff;
   assign high_kill = high_kill_ff;
   assign low_kill  = low_kill_ff;

endmodule

FILE: rtl/spd_chain.sv
module spd_chain import spd_pkg::*; #(
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
   localparam int WW = $clog2(MAX_HALF_WINDOW + 1)
) (
   input  logic               clock,
   input  logic               shift_en,
   input  logic [PRICE_W-1:0] bar_high,
   input  logic [PRICE_W-1:0] bar_low,
   input  logic               cmp_en,
   input  logic [PRICE_W-1:0] cand_high,
   input  logic [PRICE_W-1:0] cand_low,
   input  logic [WW-1:0]      win,
   output verdict_type        verdict
);

   localparam int NC = 2 * MAX_HALF_WINDOW + 1;

   logic [PRICE_W-1:0] high_link [NC+1];
   logic [PRICE_W-1:0] low_link  [NC+1];
   logic [NC-1:0]      high_kill;
   logic [NC-1:0]      low_kill;

   assign high_link[0] = bar_high;
   assign low_link[0]  = bar_low;

   for (genvar k = 0; k < NC; k++) begin : g_cell
      spd_cell #(
         .POS (k),
         .WW  (WW)
      ) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .prev_high (high_link[k]),
         .prev_low  (low_link[k]),
         .cell_high (high_link[k+1]),
         .cell_low  (low_link[k+1]),
         .cmp_en    (cmp_en),
         .cand_high (cand_high),
         .cand_low  (cand_low),
         .win       (win),
         .high_kill (high_kill[k]),
         .low_kill  (low_kill[k])
      );
   end

   assign verdict.is_high = ~|high_kill;
   assign verdict.is_low  = ~|low_kill;

endmodule
